>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on aclk, reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define GRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define GRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants of the grid ray caster column block.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int CFG_W      = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int RAY_W      = 33;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 64;
    localparam int SPAN_MAX   = 4095;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_W   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_H   = 3'd7;

    // Register reset values
    localparam logic [20:0]        RST_POS_X   = 21'd786432;
    localparam logic [20:0]        RST_POS_Y   = 21'd327680;
    localparam logic signed [18:0] RST_DIR_X   = -19'sd65536;
    localparam logic signed [18:0] RST_DIR_Y   = 19'sd0;
    localparam logic signed [18:0] RST_PLANE_X = 19'sd0;
    localparam logic signed [18:0] RST_PLANE_Y = 19'sd43254;
    localparam logic [12:0]        RST_SCR_W   = 13'd640;
    localparam logic [12:0]        RST_SCR_H   = 13'd480;

    // Input operation codes
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_CAST  = 1'b1;

    // Wall codes and colours
    localparam logic [2:0]  CODE_RED   = 3'd1;
    localparam logic [2:0]  CODE_GREEN = 3'd2;
    localparam logic [2:0]  CODE_BLUE  = 3'd3;
    localparam logic [2:0]  CODE_WHITE = 3'd4;
    localparam logic [23:0] COL_RED    = 24'hFF0000;
    localparam logic [23:0] COL_GREEN  = 24'h00FF00;
    localparam logic [23:0] COL_BLUE   = 24'h0000FF;
    localparam logic [23:0] COL_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] COL_YELLOW = 24'hFFFF00;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAM_DIV,
        OP_CAM_SET,
        OP_RAY_MUL,
        OP_RAY_SET,
        OP_DX_DIV,
        OP_DX_SET,
        OP_DY_DIV,
        OP_DY_SET,
        OP_SIDE_MUL,
        OP_SIDE_SET,
        OP_STEP,
        OP_TEST,
        OP_PERP_DIV,
        OP_PERP_SET,
        OP_LH_DIV,
        OP_LH_SET,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } grc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic clear_last;
        logic test_hit;
        logic walk_last;
    } grc_stat_t;

    function automatic logic [23:0] wall_rgb(input logic [2:0] code);
        logic [23:0] c;
        unique case (code)
            CODE_RED:   c = COL_RED;
            CODE_GREEN: c = COL_GREEN;
            CODE_BLUE:  c = COL_BLUE;
            CODE_WHITE: c = COL_WHITE;
            default:    c = COL_YELLOW;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/grc_div.sv
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div #(
    parameter int DW = 41,
    parameter int VW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [VW:0]      trial, diff;
    logic             ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/grc_dp.sv
// ----------------------------------------------------------------------------
// grc_dp
// Datapath: registers, map memory, multipliers, divider and DDA walk.
// ----------------------------------------------------------------------------
module grc_dp #(
    parameter int MAP_SIZE  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  grc_pkg::grc_cmd_t                   cmd,
    output grc_pkg::grc_stat_t                  stat,
    input  logic                                in_accept,
    input  logic                                in_op,
    input  logic [4:0]                          cell_x,
    input  logic [4:0]                          cell_y,
    input  logic [2:0]                          cell_value,
    input  logic [11:0]                         column,
    input  logic                                cfg_wr_en,
    input  logic [grc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]           cfg_wdata,
    output logic [11:0]                         out_column,
    output logic [11:0]                         draw_start,
    output logic [11:0]                         draw_end,
    output logic [23:0]                         wall_color,
    output logic                                hit_side,
    output logic [2:0]                          wall_code
);
    import grc_pkg::*;

    localparam int F        = FRAC_BITS;
    localparam int DIST_W   = F + 14;
    localparam int MW       = (((21 - F) > 7) ? (21 - F) : 7) + 2;
    localparam int NW       = F + MW + 1;
    localparam int CAM_W    = F + 14;
    localparam int DW       = 2 * F + MW;
    localparam int VW       = ((F + 14) > 32) ? (F + 14) : 32;
    localparam int OA       = ((F + 2) > 19) ? (F + 2) : 19;
    localparam int OB       = F + 15;
    localparam int PW       = OA + OB;
    localparam int LHW      = F + 14;
    localparam int DEPTH    = MAP_SIZE * MAP_SIZE;
    localparam int AW       = $clog2(DEPTH);
    localparam int WALK_MAX = 4 * MAP_SIZE + 4;
    localparam int CW       = $clog2(WALK_MAX);

    localparam logic [DIST_W-1:0]     DIST_MAX = '1;
    localparam logic [DW-1:0]         DMAX_Q   = DW'(DIST_MAX);
    localparam logic signed [NW-1:0]  ONE_N    = NW'(1) << F;
    localparam logic signed [CAM_W-1:0] ONE_C  = CAM_W'(1) << F;
    localparam logic signed [MW-1:0]  MAP_S    = MW'(MAP_SIZE);

    // configuration
    logic [20:0]        pos_x_reg, pos_y_reg;
    logic signed [18:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [12:0]        scr_w_reg, scr_h_reg;
    logic [12:0]        w_eff, h_eff;

    // cast state
    logic [11:0]              col_reg;
    logic signed [CAM_W-1:0]  cam_reg;
    logic signed [RAY_W-1:0]  rx_reg, ry_reg;
    logic [DIST_W-1:0]        dx_reg, dy_reg, sx_reg, sy_reg, perp_reg;
    logic signed [MW-1:0]     mx_reg, my_reg;
    logic                     stx_neg_reg, sty_neg_reg, side_reg;
    logic                     offmap_reg;
    logic [2:0]               rd_reg, code_reg;
    logic [CW-1:0]            cnt_reg;
    logic signed [PW-1:0]     prod_a_reg, prod_b_reg;
    logic                     perp_sat_reg, perp_zero_reg;
    logic [LHW-1:0]           lh_reg;
    logic [AW-1:0]            clr_cnt_reg;

    logic [2:0] mem [DEPTH];

    // output register
    logic [11:0] o_col_reg, o_ds_reg, o_de_reg;
    logic [23:0] o_color_reg;
    logic        o_side_reg;
    logic [2:0]  o_code_reg;

    // divider
    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_quo;
    logic [VW-1:0] div_divisor;

    grc_div #(.DW(DW), .VW(VW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign w_eff = (scr_w_reg == 13'd0) ? 13'd1 : scr_w_reg;
    assign h_eff = (scr_h_reg == 13'd0) ? 13'd1 : scr_h_reg;

    // ---------------- combinational helpers ----------------
    logic [RAY_W-1:0]         rx_abs, ry_abs, ray_abs;
    logic signed [RAY_W-1:0]  ray_sel;
    logic signed [MW-1:0]     mx0, my0;
    logic signed [NW-1:0]     px_n, py_n, offx, offy, num;
    logic [NW-1:0]            num_abs;
    logic [20:0]              px_int, py_int;

    always_comb begin
        rx_abs  = rx_reg[RAY_W-1] ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
        ry_abs  = ry_reg[RAY_W-1] ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);
        ray_sel = side_reg ? ry_reg : rx_reg;
        ray_abs = side_reg ? ry_abs : rx_abs;
        px_int  = pos_x_reg >> F;
        py_int  = pos_y_reg >> F;
        mx0     = MW'($signed({1'b0, px_int}));
        my0     = MW'($signed({1'b0, py_int}));
        px_n    = NW'($signed({1'b0, pos_x_reg}));
        py_n    = NW'($signed({1'b0, pos_y_reg}));
        offx    = rx_reg[RAY_W-1] ? (px_n - (NW'(mx0) <<< F))
                                  : ((NW'(mx0) <<< F) + ONE_N - px_n);
        offy    = ry_reg[RAY_W-1] ? (py_n - (NW'(my0) <<< F))
                                  : ((NW'(my0) <<< F) + ONE_N - py_n);
        if (side_reg) begin
            num = (NW'(my_reg) <<< F) - py_n + (sty_neg_reg ? ONE_N : '0);
        end else begin
            num = (NW'(mx_reg) <<< F) - px_n + (stx_neg_reg ? ONE_N : '0);
        end
        num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    end

    // divider operands
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (cmd.op)
            OP_CAM_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(col_reg) << (F + 1);
                div_divisor  = VW'(w_eff);
            end
            OP_DX_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(1) << (2 * F);
                div_divisor  = VW'(rx_abs);
            end
            OP_DY_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(1) << (2 * F);
                div_divisor  = VW'(ry_abs);
            end
            OP_PERP_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(num_abs) << F;
                div_divisor  = VW'(ray_abs);
            end
            OP_LH_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(h_eff) << F;
                div_divisor  = VW'(perp_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // multiplier operands
    logic signed [OA-1:0] mul_a1, mul_a2;
    logic signed [OB-1:0] mul_b1, mul_b2;

    always_comb begin
        if (cmd.op == OP_SIDE_MUL) begin
            mul_a1 = OA'(offx);
            mul_a2 = OA'(offy);
            mul_b1 = OB'($signed({1'b0, dx_reg}));
            mul_b2 = OB'($signed({1'b0, dy_reg}));
        end else begin
            mul_a1 = OA'(plane_x_reg);
            mul_a2 = OA'(plane_y_reg);
            mul_b1 = OB'(cam_reg);
            mul_b2 = OB'(cam_reg);
        end
    end

    // truncating scale of a product toward zero
    function automatic logic signed [RAY_W-1:0] scale_trunc(input logic signed [PW-1:0] p);
        logic [PW-1:0]           pabs;
        logic [PW-1:0]           sh;
        logic signed [RAY_W-1:0] v;
        pabs = p[PW-1] ? PW'(-p) : PW'(p);
        sh   = pabs >> F;
        v    = RAY_W'(sh);
        return p[PW-1] ? -v : v;
    endfunction

    // DDA step
    logic                     step_x;
    logic [DIST_W:0]          sum_x, sum_y;
    logic signed [MW-1:0]     mx_nx, my_nx;
    logic                     off_nx;
    logic [AW-1:0]            step_addr, wr_addr;
    logic                     wr_in_map;

    always_comb begin
        step_x = sx_reg < sy_reg;
        sum_x  = {1'b0, sx_reg} + {1'b0, dx_reg};
        sum_y  = {1'b0, sy_reg} + {1'b0, dy_reg};
        mx_nx  = mx_reg;
        my_nx  = my_reg;
        if (step_x) begin
            mx_nx = stx_neg_reg ? (mx_reg - MW'(1)) : (mx_reg + MW'(1));
        end else begin
            my_nx = sty_neg_reg ? (my_reg - MW'(1)) : (my_reg + MW'(1));
        end
        off_nx    = mx_nx[MW-1] || my_nx[MW-1] || (mx_nx >= MAP_S) || (my_nx >= MAP_S);
        step_addr = AW'(AW'(mx_nx) * AW'(MAP_SIZE)) + AW'(my_nx);
        wr_addr   = AW'(AW'(cell_x) * AW'(MAP_SIZE)) + AW'(cell_y);
        wr_in_map = ({3'b000, cell_x} < 8'(MAP_SIZE)) && ({3'b000, cell_y} < 8'(MAP_SIZE));
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= RST_POS_X;
            pos_y_reg   <= RST_POS_Y;
            dir_x_reg   <= RST_DIR_X;
            dir_y_reg   <= RST_DIR_Y;
            plane_x_reg <= RST_PLANE_X;
            plane_y_reg <= RST_PLANE_Y;
            scr_w_reg   <= RST_SCR_W;
            scr_h_reg   <= RST_SCR_H;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.op == OP_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_POS_X:   pos_x_reg   <= cfg_wdata;
                    REG_POS_Y:   pos_y_reg   <= cfg_wdata;
                    REG_DIR_X:   dir_x_reg   <= cfg_wdata[18:0];
                    REG_DIR_Y:   dir_y_reg   <= cfg_wdata[18:0];
                    REG_PLANE_X: plane_x_reg <= cfg_wdata[18:0];
                    REG_PLANE_Y: plane_y_reg <= cfg_wdata[18:0];
                    REG_SCR_W:   scr_w_reg   <= cfg_wdata[12:0];
                    REG_SCR_H:   scr_h_reg   <= cfg_wdata[12:0];
                    default:     scr_h_reg   <= scr_h_reg;
                endcase
            end
        end
    end

    // ---------------- map memory ----------------
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CLEAR) begin
            mem[clr_cnt_reg] <= 3'd0;
        end else if (in_accept && (in_op == OPC_WRITE) && wr_in_map) begin
            mem[wr_addr] <= cell_value;
        end
        if (cmd.op == OP_STEP) begin
            rd_reg <= mem[step_addr];
        end
    end

    // ---------------- span and colour ----------------
    logic [LHW-1:0] half;
    logic [11:0]    hh;
    logic [LHW:0]   de_sum;
    logic [12:0]    de13;
    logic [11:0]    ds_val, de_val;
    logic [23:0]    rgb;

    always_comb begin
        half   = lh_reg >> 1;
        hh     = h_eff[12:1];
        de_sum = {1'b0, half} + (LHW + 1)'(hh);
        if (perp_reg == '0) begin
            ds_val = 12'd0;
            de13   = h_eff - 13'd1;
        end else begin
            ds_val = (half > LHW'(hh)) ? 12'd0 : (hh - half[11:0]);
            de13   = (de_sum >= (LHW + 1)'(h_eff)) ? (h_eff - 13'd1) : de_sum[12:0];
        end
        de_val = (de13 > 13'(SPAN_MAX)) ? 12'(SPAN_MAX) : de13[11:0];
        rgb    = wall_rgb(code_reg);
        if (side_reg) begin
            rgb = rgb >> 1;
        end
    end

    // ---------------- cast sequencing ----------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            col_reg <= column;
        end
        unique case (cmd.op)
            OP_CAM_SET: cam_reg <= CAM_W'(div_quo) - ONE_C;
            OP_RAY_MUL: begin
                prod_a_reg <= mul_a1 * mul_b1;
                prod_b_reg <= mul_a2 * mul_b2;
            end
            OP_RAY_SET: begin
                rx_reg <= RAY_W'(dir_x_reg) + scale_trunc(prod_a_reg);
                ry_reg <= RAY_W'(dir_y_reg) + scale_trunc(prod_b_reg);
            end
            OP_DX_SET: dx_reg <= ((rx_reg == '0) || (div_quo > DMAX_Q)) ? DIST_MAX
                                                                     : div_quo[DIST_W-1:0];
            OP_DY_SET: dy_reg <= ((ry_reg == '0) || (div_quo > DMAX_Q)) ? DIST_MAX
                                                                     : div_quo[DIST_W-1:0];
            OP_SIDE_MUL: begin
                prod_a_reg  <= mul_a1 * mul_b1;
                prod_b_reg  <= mul_a2 * mul_b2;
                mx_reg      <= mx0;
                my_reg      <= my0;
                stx_neg_reg <= rx_reg[RAY_W-1];
                sty_neg_reg <= ry_reg[RAY_W-1];
            end
            OP_SIDE_SET: begin
                sx_reg   <= prod_a_reg[F+DIST_W-1:F];
                sy_reg   <= prod_b_reg[F+DIST_W-1:F];
                cnt_reg  <= '0;
                side_reg <= 1'b0;
            end
            OP_STEP: begin
                if (step_x) begin
                    sx_reg   <= sum_x[DIST_W] ? DIST_MAX : sum_x[DIST_W-1:0];
                    side_reg <= 1'b0;
                end else begin
                    sy_reg   <= sum_y[DIST_W] ? DIST_MAX : sum_y[DIST_W-1:0];
                    side_reg <= 1'b1;
                end
                mx_reg     <= mx_nx;
                my_reg     <= my_nx;
                offmap_reg <= off_nx;
            end
            OP_TEST: begin
                code_reg <= offmap_reg ? 3'd0 : rd_reg;
                cnt_reg  <= cnt_reg + CW'(1);
            end
            OP_PERP_DIV: begin
                perp_sat_reg  <= ray_sel == '0;
                perp_zero_reg <= (num == '0) || (num[NW-1] != ray_sel[RAY_W-1]);
            end
            OP_PERP_SET: begin
                if (perp_sat_reg) begin
                    perp_reg <= DIST_MAX;
                end else if (perp_zero_reg) begin
                    perp_reg <= '0;
                end else begin
                    perp_reg <= (div_quo > DMAX_Q) ? DIST_MAX : div_quo[DIST_W-1:0];
                end
            end
            OP_LH_SET: lh_reg <= div_quo[LHW-1:0];
            OP_OUT: begin
                o_col_reg   <= col_reg;
                o_ds_reg    <= ds_val;
                o_de_reg    <= de_val;
                o_color_reg <= rgb;
                o_side_reg  <= side_reg;
                o_code_reg  <= code_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        stat.div_done   = div_done;
        stat.clear_last = clr_cnt_reg == AW'(DEPTH - 1);
        stat.test_hit   = offmap_reg || (rd_reg != 3'd0);
        stat.walk_last  = cnt_reg == CW'(WALK_MAX - 1);
    end

    assign out_column = o_col_reg;
    assign draw_start = o_ds_reg;
    assign draw_end   = o_de_reg;
    assign wall_color = o_color_reg;
    assign hit_side   = o_side_reg;
    assign wall_code  = o_code_reg;

endmodule

>>> rtl/core/grc_ctrl.sv
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer for map clearing, map writes and column casts.
// ----------------------------------------------------------------------------
module grc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic               in_op,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output grc_pkg::grc_cmd_t  cmd,
    input  grc_pkg::grc_stat_t stat
);
    import grc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CAM_DIV, S_CAM_WAIT, S_RAY_MUL, S_RAY_SET,
        S_DX_DIV, S_DX_WAIT, S_DY_DIV, S_DY_WAIT, S_SIDE_MUL, S_SIDE_SET,
        S_STEP, S_TEST, S_PERP_DIV, S_PERP_WAIT, S_LH_DIV, S_LH_WAIT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    dp_op_t op;

    always_comb begin
        state_next     = state_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR: begin
                op = OP_CLEAR;
                if (stat.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept && (in_op == OPC_CAST)) state_next = S_CAM_DIV;
            end
            S_CAM_DIV: begin
                op         = OP_CAM_DIV;
                state_next = S_CAM_WAIT;
            end
            S_CAM_WAIT: begin
                if (stat.div_done) begin
                    op         = OP_CAM_SET;
                    state_next = S_RAY_MUL;
                end
            end
            S_RAY_MUL: begin
                op         = OP_RAY_MUL;
                state_next = S_RAY_SET;
            end
            S_RAY_SET: begin
                op         = OP_RAY_SET;
                state_next = S_DX_DIV;
            end
            S_DX_DIV: begin
                op         = OP_DX_DIV;
                state_next = S_DX_WAIT;
            end
            S_DX_WAIT: begin
                if (stat.div_done) begin
                    op         = OP_DX_SET;
                    state_next = S_DY_DIV;
                end
            end
            S_DY_DIV: begin
                op         = OP_DY_DIV;
                state_next = S_DY_WAIT;
            end
            S_DY_WAIT: begin
                if (stat.div_done) begin
                    op         = OP_DY_SET;
                    state_next = S_SIDE_MUL;
                end
            end
            S_SIDE_MUL: begin
                op         = OP_SIDE_MUL;
                state_next = S_SIDE_SET;
            end
            S_SIDE_SET: begin
                op         = OP_SIDE_SET;
                state_next = S_STEP;
            end
            S_STEP: begin
                op         = OP_STEP;
                state_next = S_TEST;
            end
            S_TEST: begin
                op         = OP_TEST;
                state_next = (stat.test_hit || stat.walk_last) ? S_PERP_DIV : S_STEP;
            end
            S_PERP_DIV: begin
                op         = OP_PERP_DIV;
                state_next = S_PERP_WAIT;
            end
            S_PERP_WAIT: begin
                if (stat.div_done) begin
                    op         = OP_PERP_SET;
                    state_next = S_LH_DIV;
                end
            end
            S_LH_DIV: begin
                op         = OP_LH_DIV;
                state_next = S_LH_WAIT;
            end
            S_LH_WAIT: begin
                if (stat.div_done) begin
                    op         = OP_LH_SET;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // load the output register once the previous result has gone
                if (!out_valid_reg || out_ready) begin
                    op             = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;

endmodule

>>> rtl/core/grid_ray_caster_column_top.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_column_top
// Untextured DDA grid ray caster, one screen column per cast transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction either writes a map cell (s_tuser = 0) or
//   casts one screen column (s_tuser = 1). A write gives no result, and
//   s_tready stays high. A cast gives one m_ transaction.
//   cfg port: write-only registers, taken on any edge with cfg_wr_en high,
//   to be written only while no cast is in flight.
//   A cast runs five divisions on one shared restoring divider and, for
//   each grid step of the walk, a memory read, then a hit test; the walk
//   is bounded by 4*MAP_SIZE+4 steps. One cast is in work at a time.
//   Reset: a clearing pass writes every map cell to zero, one cell a cycle,
//   MAP_SIZE*MAP_SIZE cells (1024 at the defaults); s_tready is low meanwhile.
//   Stall: a finished result waits in the output register; the block takes a
//   new transaction meanwhile and holds a further result until m_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_ray_caster_column_top #(
    parameter int MAP_SIZE  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cell_x[4:0], cell_y[9:5], cell_value[12:10], column[24:13], zero pad
    input  logic [grc_pkg::S_TDATA_W-1:0]     s_tdata,
    // op[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_column[11:0], draw_start[23:12], draw_end[35:24],
    // wall_color[59:36], hit_side[60], wall_code[63:61]
    output logic [grc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [grc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]         cfg_wdata
);
    import grc_pkg::*;

    grc_cmd_t    cmd;
    grc_stat_t   stat;
    logic        in_accept;
    logic [11:0] out_column, draw_start, draw_end;
    logic [23:0] wall_color;
    logic        hit_side;
    logic [2:0]  wall_code;

    assign in_accept = s_tvalid && s_tready;

    grc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    grc_dp #(
        .MAP_SIZE  (MAP_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_accept  (in_accept),
        .in_op      (s_tuser),
        .cell_x     (s_tdata[4:0]),
        .cell_y     (s_tdata[9:5]),
        .cell_value (s_tdata[12:10]),
        .column     (s_tdata[24:13]),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_column (out_column),
        .draw_start (draw_start),
        .draw_end   (draw_end),
        .wall_color (wall_color),
        .hit_side   (hit_side),
        .wall_code  (wall_code)
    );

    assign m_tdata = {wall_code, hit_side, wall_color, draw_end, draw_start, out_column};

    `GRC_ASSERT_ALWAYS(a_reset_no_result, !aresetn |=> !m_tvalid, "result valid after reset")
    `GRC_ASSERT(a_cast_busy, (s_tvalid && s_tready && s_tuser) |=> !s_tready,
        "cast transaction did not make the block busy")
    `GRC_ASSERT(a_write_idle, (s_tvalid && s_tready && !s_tuser) |=> s_tready,
        "map write transaction left the block busy")
    `GRC_ASSERT(a_result_from_cast, $rose(m_tvalid) |-> $past(!s_tready),
        "result appeared while the block was idle")

endmodule
